[rtl/fasta_sequence_deframer_defines.svh]
// -----------------------------------------------------------------------------
// fasta_sequence_deframer_defines
// Assertion macros for the checker file of the deframer.
// -----------------------------------------------------------------------------
`ifndef FASTA_SEQUENCE_DEFRAMER_DEFINES_SVH
`define FASTA_SEQUENCE_DEFRAMER_DEFINES_SVH

// Checked on every clock edge outside reset.
`define FSD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define FSD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/fsd_pkg.sv]
// -----------------------------------------------------------------------------
// fsd_pkg
// Shared types and constants of the FASTA sequence deframer.
// -----------------------------------------------------------------------------
package fsd_pkg;

	localparam int RECORD_INDEX_BITS = 24;
	localparam int INDEX_OUT_BITS    = 24;

	localparam int QUEUE_DEPTH    = 4;
	localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		KIND_RESIDUE = 2'd0,
		KIND_END     = 2'd1,
		KIND_ERROR   = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		CLS_LF,
		CLS_WS,
		CLS_GT,
		CLS_KEEP,
		CLS_DROP,
		CLS_EOI
	} byte_class_t;

	typedef struct packed {
		byte_class_t cls;
		logic [7:0]  upper;
	} fsd_item_t;

endpackage

[rtl/fasta_sequence_deframer.sv]
// -----------------------------------------------------------------------------
// fasta_sequence_deframer: FASTA text in; residues, record ends and errors out.
// Throughput: one item per cycle while results are popped; full stalls the input.
// An accepted item passes the middle queue; its result is registered in the back end.
// Reset (arst_n low, async): queue and output empty, line start, no record open, index 0.
// -----------------------------------------------------------------------------
module fasta_sequence_deframer import fsd_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	// input side: queue-style push/full
	input  logic                      push,
	output logic                      full,
	input  logic                      action,
	input  logic [7:0]                text_byte,
	// result side: queue-style empty/pop
	output logic                      empty,
	input  logic                      pop,
	output logic [1:0]                kind,
	output logic [7:0]                residue,
	output logic [INDEX_OUT_BITS-1:0] record_index
);

	// Front end: takes an item whenever the middle queue has room and reduces
	// the byte to a class plus its uppercased value. No state lives here.
	logic      wr_en;
	fsd_item_t wr_item;

	// Middle queue: lets the front keep accepting while the back end waits on
	// a result that has not been popped yet.
	logic      q_not_empty;
	logic      q_take;
	fsd_item_t q_item;

	fsd_front u_front (
		.push       (push),
		.action     (action),
		.text_byte  (text_byte),
		.queue_full (full),
		.wr_en      (wr_en),
		.wr_item    (wr_item)
	);

	fsd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_item   (wr_item),
		.full      (full),
		.rd_en     (q_take),
		.rd_item   (q_item),
		.not_empty (q_not_empty)
	);

	// Back end: line mode, open flag and record counter. It drains one item a
	// cycle as long as its output register is free or being popped, so an
	// item that gives no result never blocks the stream.
	fsd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (q_not_empty),
		.in_item      (q_item),
		.in_take      (q_take),
		.pop          (pop),
		.empty        (empty),
		.kind         (kind),
		.residue      (residue),
		.record_index (record_index)
	);

endmodule

[rtl/fsd_front.sv]
// -----------------------------------------------------------------------------
// fsd_front
// Accepts input items and classifies each byte for the back end.
// -----------------------------------------------------------------------------
module fsd_front import fsd_pkg::*; (
	input  logic       push,
	input  logic       action,
	input  logic [7:0] text_byte,
	input  logic       queue_full,
	output logic       wr_en,
	output fsd_item_t  wr_item
);

	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_GT  = 8'h3E;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_QM  = 8'h3F;
	localparam logic [7:0] CH_AST = 8'h2A;
	localparam logic [7:0] CH_UA  = 8'h41;
	localparam logic [7:0] CH_UZ  = 8'h5A;
	localparam logic [7:0] CH_LA  = 8'h61;
	localparam logic [7:0] CH_LZ  = 8'h7A;
	localparam logic [7:0] CASE_OFS = 8'h20;

	logic [7:0] upper;
	logic       is_ws;
	logic       is_kept;

	assign wr_en = push && !queue_full;

	always_comb begin
		upper = text_byte;
		if (text_byte >= CH_LA && text_byte <= CH_LZ) begin
			upper = text_byte - CASE_OFS;
		end
	end

	assign is_ws   = (text_byte == CH_SP) || (text_byte >= CH_TAB && text_byte <= CH_CR);
	assign is_kept = (upper == CH_DOT) || (upper == CH_QM) || (upper == CH_AST) ||
		(upper >= CH_UA && upper <= CH_UZ);

	always_comb begin
		wr_item.upper = upper;
		if (action) begin
			wr_item.cls = CLS_EOI;
		end else if (text_byte == CH_LF) begin
			wr_item.cls = CLS_LF;
		end else if (is_ws) begin
			wr_item.cls = CLS_WS;
		end else if (text_byte == CH_GT) begin
			wr_item.cls = CLS_GT;
		end else if (is_kept) begin
			wr_item.cls = CLS_KEEP;
		end else begin
			wr_item.cls = CLS_DROP;
		end
	end

endmodule

[rtl/fsd_queue.sv]
// -----------------------------------------------------------------------------
// fsd_queue
// Short register queue between the front and the back end.
// -----------------------------------------------------------------------------
module fsd_queue import fsd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_en,
	input  fsd_item_t wr_item,
	output logic      full,
	input  logic      rd_en,
	output fsd_item_t rd_item,
	output logic      not_empty
);

	fsd_item_t                 mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_BITS-1:0] wr_ptr_q;
	logic [QUEUE_PTR_BITS-1:0] rd_ptr_q;
	logic [QUEUE_CNT_BITS-1:0] count_q;

	assign full      = (count_q == QUEUE_CNT_BITS'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/fsd_back.sv]
// -----------------------------------------------------------------------------
// fsd_back
// Line and record tracking; produces residues, record ends and errors.
// -----------------------------------------------------------------------------
module fsd_back import fsd_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  fsd_item_t                 in_item,
	output logic                      in_take,
	input  logic                      pop,
	output logic                      empty,
	output logic [1:0]                kind,
	output logic [7:0]                residue,
	output logic [INDEX_OUT_BITS-1:0] record_index
);

	typedef enum logic [1:0] {
		MODE_START,
		MODE_SEQ,
		MODE_HDR
	} mode_t;

	mode_t                        mode_q, mode_d;
	logic                         open_q, open_d;
	logic [RECORD_INDEX_BITS-1:0] count_q, count_d;
	logic                         out_valid_q;
	kind_t                        kind_q, kind_d;
	logic [7:0]                   residue_q, residue_d;
	logic [INDEX_OUT_BITS-1:0]    index_q;
	logic                         has_res;

	// output slot frees up when empty or being taken this cycle
	assign in_take = in_valid && (!out_valid_q || pop);

	always_comb begin
		logic seq_line;
		seq_line  = 1'b0;
		mode_d    = mode_q;
		open_d    = open_q;
		count_d   = count_q;
		has_res   = 1'b0;
		kind_d    = KIND_RESIDUE;
		residue_d = '0;
		if (in_take) begin
			if (in_item.cls == CLS_EOI) begin
				has_res = 1'b1;
				kind_d  = open_q ? KIND_END : KIND_ERROR;
				mode_d  = MODE_START;
				open_d  = 1'b0;
				count_d = '0;
			end else if (in_item.cls == CLS_LF) begin
				mode_d = MODE_START;
			end else begin
				unique case (mode_q)
					MODE_START: begin
						if (in_item.cls == CLS_GT) begin
							mode_d = MODE_HDR;
							if (open_q) begin
								has_res = 1'b1;
								kind_d  = KIND_END;
								open_d  = 1'b0;
								if (count_q != '1) begin
									count_d = count_q + 1'b1;
								end
							end
						end else if (in_item.cls != CLS_WS) begin
							mode_d   = MODE_SEQ;
							seq_line = 1'b1;
						end
					end
					MODE_SEQ: begin
						seq_line = 1'b1;
					end
					default: begin
						// header body: ignored up to the next LF
					end
				endcase
				if (seq_line && in_item.cls != CLS_WS) begin
					open_d = 1'b1;
					if (in_item.cls == CLS_KEEP) begin
						has_res   = 1'b1;
						residue_d = in_item.upper;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_START;
			open_q      <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			kind_q      <= KIND_RESIDUE;
			residue_q   <= '0;
			index_q     <= '0;
		end else begin
			mode_q  <= mode_d;
			open_q  <= open_d;
			count_q <= count_d;
			if (in_take) begin
				out_valid_q <= has_res;
				if (has_res) begin
					kind_q    <= kind_d;
					residue_q <= residue_d;
					index_q   <= INDEX_OUT_BITS'(count_q);
				end
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty        = !out_valid_q;
	assign kind         = kind_q;
	assign residue      = residue_q;
	assign record_index = index_q;

endmodule

[rtl/fsd_checker.sv]
// -----------------------------------------------------------------------------
// fsd_checker
// Port-level checks of the deframer, bound to the top level.
// -----------------------------------------------------------------------------
`include "fasta_sequence_deframer_defines.svh"

module fsd_checker import fsd_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      full,
	input logic                      empty,
	input logic                      pop,
	input logic [1:0]                kind,
	input logic [7:0]                residue,
	input logic [INDEX_OUT_BITS-1:0] record_index
);

	logic                      shown;
	logic                      kind_ok;
	logic                      res_kept;
	logic [INDEX_OUT_BITS+9:0] result_word;

	assign shown       = !empty;
	assign kind_ok     = (kind == KIND_RESIDUE) || (kind == KIND_END) || (kind == KIND_ERROR);
	assign res_kept    = (residue == 8'h2E) || (residue == 8'h3F) || (residue == 8'h2A) ||
		(residue >= 8'h41 && residue <= 8'h5A);
	assign result_word = {kind, residue, record_index};

	`FSD_ASSERT_ALWAYS(a_idle_in_reset, !arst_n |-> (empty && !full), "busy during reset")
	`FSD_ASSERT(a_kind_legal, shown |-> kind_ok, "illegal result kind")
	`FSD_ASSERT(a_residue_zero, (shown && !res_kept) |-> (residue == 8'h00), "stray residue")
	`FSD_ASSERT(a_residue_kept, (shown && kind == KIND_RESIDUE) |-> res_kept, "residue not kept")
	`FSD_ASSERT(a_result_holds, (shown && !pop) |=> (shown && $stable(result_word)), "result changed")

endmodule

bind fasta_sequence_deframer fsd_checker u_fsd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.full         (full),
	.empty        (empty),
	.pop          (pop),
	.kind         (kind),
	.residue      (residue),
	.record_index (record_index)
);
